@@ sv/suks_pkg.sv @@
`timescale 1ns / 1ps

package suks_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

@@ sv/suks_cell.sv @@
`timescale 1ns / 1ps

module suks_cell
    import suks_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctl_t               ctl,
    input  logic signed [KEY_W-1:0] key,
    input  logic signed [KEY_W-1:0] prev_key,
    input  logic                    prev_valid,
    input  logic                    prev_gt,
    input  logic signed [KEY_W-1:0] next_key,
    input  logic                    next_valid,
    output logic signed [KEY_W-1:0] key_q,
    output logic                    valid_q,
    output logic                    eq,
    output logic                    gt
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    lt;

    // lt: new key sorts before the held key
    assign eq = valid_reg && (key_reg == key);
    assign lt = valid_reg && (key < key_reg);
    assign gt = !valid_reg || lt;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.ins && gt)
        begin
            if (prev_gt)
            begin
                key_next   = prev_key;
                valid_next = prev_valid;
            end
            else
            begin
                key_next   = key;
                valid_next = 1'b1;
            end
        end
        else if (ctl.del && (eq || lt))
        begin
            key_next   = next_key;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q   = key_reg;
    assign valid_q = valid_reg;

endmodule

@@ sv/sorted_unique_key_set.sv @@
`timescale 1ns / 1ps

// Sorted set of up to CAPACITY signed 32-bit keys with no duplicates. Each request
// (insert, delete or search) gives exactly one response with a status and the key
// count after the request. A request is taken every cycle while the response
// register is empty or being drained, and its response appears in the cycle after
// it is taken: every cell of the chain compares the key at once, and in the same
// cycle the cells above the insertion or deletion point shift by one slot. Action
// code 3 behaves as a search.
module sorted_unique_key_set
    import suks_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic signed [KEY_W-1:0] cell_key  [CAPACITY];
    logic                    cell_valid[CAPACITY];
    logic [CAPACITY-1:0]     cell_eq;
    logic [CAPACITY-1:0]     cell_gt;

    logic             take;
    logic             hit;
    logic             full;
    cell_ctl_t        ctl;
    logic [1:0]       status;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign take      = req_valid && req_ready;
    assign hit       = |cell_eq;
    assign full      = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ctl        = '0;
        count_next = count_reg;
        status     = hit ? ST_DONE : ST_ABSENT;
        case (req.action)
            ACT_INSERT:
            begin
                if (hit)
                begin
                    status = ST_DUP;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_DONE;
                    ctl.ins    = take;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                if (hit)
                begin
                    ctl.del    = take;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_SEARCH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [KEY_W-1:0] prev_key;
            logic                    prev_valid;
            logic                    prev_gt;
            logic signed [KEY_W-1:0] next_key;
            logic                    next_valid;

            if (i == 0)
            begin : g_head
                assign prev_key   = req.key;
                assign prev_valid = 1'b0;
                assign prev_gt    = 1'b0;
            end
            else
            begin : g_body
                assign prev_key   = cell_key[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_gt    = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign next_key   = req.key;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_key   = cell_key[i+1];
                assign next_valid = cell_valid[i+1];
            end

            suks_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (req.key),
                .prev_key   (prev_key),
                .prev_valid (prev_valid),
                .prev_gt    (prev_gt),
                .next_key   (next_key),
                .next_valid (next_valid),
                .key_q      (cell_key[i]),
                .valid_q    (cell_valid[i]),
                .eq         (cell_eq[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (take)
        begin
            rsp_next.status      = status;
            rsp_next.entry_count = 5'(count_next);
            rsp_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // transfer payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
